@@ sv/pcbc_pkg.sv @@
// Shared types, register indexes and constants of the colormap lookup core.
// Used by every module of the block; depends on nothing.
package pcbc_pkg;

    localparam int DEFAULT_MAX_COLORS = 128;

    localparam int IDX_W   = 7;
    localparam int CH_W    = 16;
    localparam int SLIDE_W = 8;
    localparam int CFG_AW  = 3;

    // register indexes on the configuration port
    localparam logic [CFG_AW-1:0] REG_BRIGHTNESS = 3'd0;
    localparam logic [CFG_AW-1:0] REG_CONTRAST   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_COLORS     = 3'd2;
    localparam logic [CFG_AW-1:0] REG_SOURCE     = 3'd3;
    localparam logic [CFG_AW-1:0] REG_REVERSE    = 3'd4;

    localparam logic [SLIDE_W-1:0] BRIGHTNESS_RST = 8'd128;
    localparam logic [SLIDE_W-1:0] CONTRAST_RST   = 8'd128;
    localparam logic [SLIDE_W-1:0] COLORS_RST     = 8'd128;
    localparam logic [SLIDE_W-1:0] MIN_COLORS     = 8'd2;

    // item function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_MAP   = 1'b1;

    // palette source codes
    localparam logic SRC_RAMP   = 1'b0;
    localparam logic SRC_LOADED = 1'b1;

    // gray ramp divider: (j+1)*65792 / n, restoring, 4 bits per stage
    localparam int DIV_DVD_W          = 24;
    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int DIV_STAGES         = DIV_DVD_W / DIV_BITS_PER_STAGE;
    localparam int RAMP_Q_W           = 17;
    localparam logic [RAMP_Q_W-1:0] RAMP_Q_MAX = 17'd65792;
    localparam logic [CH_W-1:0]     GRAY_MAX   = 16'hFFFF;

    typedef struct packed {
        logic              func;
        logic [IDX_W-1:0]  color_index;
        logic [CH_W-1:0]   red_in;
        logic [CH_W-1:0]   green_in;
        logic [CH_W-1:0]   blue_in;
    } pix_in_t;

    typedef struct packed {
        logic [CH_W-1:0]   red_out;
        logic [CH_W-1:0]   green_out;
        logic [CH_W-1:0]   blue_out;
        logic [IDX_W-1:0]  palette_entry;
    } pix_out_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    // live settings, palette size already clamped
    typedef struct packed {
        logic [SLIDE_W-1:0] brightness;
        logic [SLIDE_W-1:0] contrast;
        logic [SLIDE_W-1:0] n_colors;
        logic               palette_source;
        logic               reverse_palette;
    } ctl_t;

    // index pipeline result: entry is the write address or the remapped j
    typedef struct packed {
        logic               func;
        logic               black;
        logic [SLIDE_W-1:0] entry;
        rgb_t               rgb;
    } map_t;

    // per-item data carried beside the ramp divider
    typedef struct packed {
        logic             black;
        logic [IDX_W-1:0] entry;
        rgb_t             rgb;
    } side_t;

endpackage

@@ sv/pcbc_index_map.sv @@
// Three-stage index remap: saturate, brightness offset, contrast scale, clamp.
// Depends on pcbc_pkg.
module pcbc_index_map (
    input  logic                 aclk,
    input  logic [2:0]           stage_en,
    input  pcbc_pkg::pix_in_t    in_data,
    input  pcbc_pkg::ctl_t       ctl,
    output pcbc_pkg::map_t       out_data
);

    logic [7:0]        nm1;
    logic [6:0]        idx_sat;
    logic [9:0]        shift_next;
    logic signed [10:0] scale;
    logic signed [20:0] prod;
    logic [12:0]       j_raw;
    logic [7:0]        j_clamp;
    logic [7:0]        j_one;
    logic [7:0]        j_fin;
    logic              black;

    logic              s0_func_reg;
    logic [6:0]        s0_idx_reg;
    logic signed [9:0] s0_shift_reg;
    pcbc_pkg::rgb_t    s0_rgb_reg;

    logic              s1_func_reg;
    logic [6:0]        s1_idx_reg;
    logic signed [20:0] s1_t_reg;
    pcbc_pkg::rgb_t    s1_rgb_reg;

    pcbc_pkg::map_t    s2_reg;
    pcbc_pkg::map_t    s2_next;

    assign nm1 = ctl.n_colors - 8'd1;

    // stage 0: saturate to n-1, index + 2b - 256 (wraps into 10-bit signed)
    always_comb begin
        idx_sat    = ({1'b0, in_data.color_index} > nm1) ? nm1[6:0] : in_data.color_index;
        shift_next = {3'b000, idx_sat} + {1'b0, ctl.brightness, 1'b0} - 10'd256;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            s0_func_reg  <= in_data.func;
            s0_idx_reg   <= idx_sat;
            s0_shift_reg <= $signed(shift_next);
            s0_rgb_reg   <= '{red: in_data.red_in, green: in_data.green_in,
                              blue: in_data.blue_in};
        end
    end

    // stage 1: (5c - 512) * shifted + 64
    always_comb begin
        scale = $signed({1'b0, ctl.contrast, 2'b00} + {3'b000, ctl.contrast} - 11'd512);
        prod  = 21'(scale) * 21'(s0_shift_reg);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            s1_func_reg <= s0_func_reg;
            s1_idx_reg  <= s0_idx_reg;
            s1_t_reg    <= prod + 21'sd64;
            s1_rgb_reg  <= s0_rgb_reg;
        end
    end

    // stage 2: floor /128, clamp, lift zero to one, optional reversal
    always_comb begin
        j_raw   = s1_t_reg[20] ? 13'd0 : s1_t_reg[19:7];
        j_clamp = (j_raw > {5'd0, nm1}) ? nm1 : j_raw[7:0];
        j_one   = (j_clamp == 8'd0) ? 8'd1 : j_clamp;
        j_fin   = ctl.reverse_palette ? (ctl.n_colors - j_one) : j_one;
        black   = (s1_idx_reg == 7'd0);

        s2_next.func  = s1_func_reg;
        s2_next.black = black;
        s2_next.rgb   = s1_rgb_reg;
        if (s1_func_reg == pcbc_pkg::FUNC_WRITE) begin
            s2_next.entry = {1'b0, s1_idx_reg};
        end else if (black) begin
            s2_next.entry = 8'd0;
        end else begin
            s2_next.entry = j_fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            s2_reg <= s2_next;
        end
    end

    assign out_data = s2_reg;

endmodule

@@ sv/pcbc_palette_ram.sv @@
// Loaded palette table: write and read share one address, registered read data.
// Depends on pcbc_pkg.
module pcbc_palette_ram #(
    parameter int DEPTH = pcbc_pkg::DEFAULT_MAX_COLORS
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   addr,
    input  pcbc_pkg::rgb_t             wr_data,
    output pcbc_pkg::rgb_t             rd_data
);

    pcbc_pkg::rgb_t mem [DEPTH];
    pcbc_pkg::rgb_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/pcbc_ramp_div.sv @@
// Pipelined restoring divider for the gray ramp: (j+1)*65792 / n.
// Depends on pcbc_pkg.
module pcbc_ramp_div (
    input  logic                                  aclk,
    input  logic [pcbc_pkg::DIV_STAGES-1:0]       stage_en,
    input  logic [7:0]                            entry_in,
    input  logic [7:0]                            n_colors,
    output logic [pcbc_pkg::RAMP_Q_W-1:0]         quot
);

    typedef struct packed {
        logic [7:0]                    rem;
        logic [pcbc_pkg::DIV_DVD_W-1:0] dq;
    } div_st_t;

    function automatic div_st_t div_steps(input div_st_t st, input logic [7:0] d);
        div_st_t    s;
        logic [8:0] trial;
        logic       qbit;
        s = st;
        for (int b = 0; b < pcbc_pkg::DIV_BITS_PER_STAGE; b++) begin
            trial = {s.rem, s.dq[pcbc_pkg::DIV_DVD_W-1]};
            qbit  = (trial >= {1'b0, d});
            s.rem = qbit ? 8'(trial - {1'b0, d}) : trial[7:0];
            s.dq  = {s.dq[pcbc_pkg::DIV_DVD_W-2:0], qbit};
        end
        return s;
    endfunction

    logic [7:0] jp1;
    div_st_t    start;
    div_st_t    st_reg [pcbc_pkg::DIV_STAGES];

    // (j+1) <= 255, so (j+1)*257 is the byte repeated; times 256 appends a zero byte
    assign jp1   = entry_in + 8'd1;
    assign start = '{rem: 8'd0, dq: {jp1, jp1, 8'h00}};

    for (genvar k = 0; k < pcbc_pkg::DIV_STAGES; k++) begin : g_stage
        if (k == 0) begin : g_first
            always_ff @(posedge aclk) begin
                if (stage_en[k]) begin
                    st_reg[k] <= div_steps(start, n_colors);
                end
            end
        end else begin : g_rest
            always_ff @(posedge aclk) begin
                if (stage_en[k]) begin
                    st_reg[k] <= div_steps(st_reg[k-1], n_colors);
                end
            end
        end
    end

    assign quot = st_reg[pcbc_pkg::DIV_STAGES-1].dq[pcbc_pkg::RAMP_Q_W-1:0];

endmodule

@@ sv/pixel_colormap_brightness_contrast_core.sv @@
// Colormap lookup with brightness and contrast: top level, config registers,
// stage control and output register. Depends on pcbc_pkg and all pcbc_* modules.
//
//   channel   ports                          direction  moves
//   s_        s_valid s_ready s_data         in         pix_in_t (write or map item)
//   m_        m_valid m_ready m_data         out        pix_out_t (one per map item)
//   cfg_      cfg_we cfg_index cfg_data      in         register write, no handshake
//
// Full rate: one transfer per cycle on each side while m_ready is high. Eleven
// register stages: three index stages, palette read, six divider stages (4
// quotient bits each), output. Map items pass every stage to m_; writes update
// the palette in stage 3 and retire there. Stages load when empty or when the
// next one loads, so s_ready drops only with every stage full and m_ready low.
// Synchronous reset clears the valid bits and config; the palette is not cleared.
module pixel_colormap_brightness_contrast_core #(
    parameter int MAX_COLORS = pcbc_pkg::DEFAULT_MAX_COLORS
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  pcbc_pkg::pix_in_t             s_data,

    output logic                          m_valid,
    input  logic                          m_ready,
    output pcbc_pkg::pix_out_t            m_data,

    input  logic                          cfg_we,
    input  logic [pcbc_pkg::CFG_AW-1:0]   cfg_index,
    input  logic [pcbc_pkg::SLIDE_W-1:0]  cfg_data
);

    localparam int AW       = $clog2(MAX_COLORS);
    localparam int ST_MEM   = 3;
    localparam int ST_DIV0  = ST_MEM + 1;
    localparam int NSTAGE   = ST_DIV0 + pcbc_pkg::DIV_STAGES + 1;
    localparam int ST_OUT   = NSTAGE - 1;
    localparam logic [8:0] MAX_N = 9'(MAX_COLORS);

    // configuration registers
    logic [7:0] brightness_reg;
    logic [7:0] contrast_reg;
    logic [7:0] colors_reg;
    logic       source_reg;
    logic       reverse_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg <= pcbc_pkg::BRIGHTNESS_RST;
            contrast_reg   <= pcbc_pkg::CONTRAST_RST;
            colors_reg     <= pcbc_pkg::COLORS_RST;
            source_reg     <= pcbc_pkg::SRC_RAMP;
            reverse_reg    <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                pcbc_pkg::REG_BRIGHTNESS: brightness_reg <= cfg_data;
                pcbc_pkg::REG_CONTRAST:   contrast_reg   <= cfg_data;
                pcbc_pkg::REG_COLORS:     colors_reg     <= cfg_data;
                pcbc_pkg::REG_SOURCE:     source_reg     <= cfg_data[0];
                pcbc_pkg::REG_REVERSE:    reverse_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // palette size clamped to 2..MAX_COLORS
    logic [7:0]     n_colors;
    pcbc_pkg::ctl_t ctl;

    always_comb begin
        if (colors_reg < pcbc_pkg::MIN_COLORS) begin
            n_colors = pcbc_pkg::MIN_COLORS;
        end else if ({1'b0, colors_reg} > MAX_N) begin
            n_colors = MAX_N[7:0];
        end else begin
            n_colors = colors_reg;
        end
        ctl.brightness      = brightness_reg;
        ctl.contrast        = contrast_reg;
        ctl.n_colors        = n_colors;
        ctl.palette_source  = source_reg;
        ctl.reverse_palette = reverse_reg;
    end

    // stage occupancy and load enables
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] stage_en;

    pcbc_pkg::map_t s2_data;

    always_comb begin
        stage_en[ST_OUT] = !valid_reg[ST_OUT] || m_ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    always_comb begin
        valid_next[0] = stage_en[0] ? s_valid : valid_reg[0];
        for (int k = 1; k < NSTAGE; k++) begin
            valid_next[k] = stage_en[k] ? valid_reg[k-1] : valid_reg[k];
        end
        // write items retire at the memory
        if (stage_en[ST_MEM]) begin
            valid_next[ST_MEM] = valid_reg[ST_MEM-1] &&
                                 (s2_data.func == pcbc_pkg::FUNC_MAP);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_en[0];

    // index remap, stages 0..2
    pcbc_index_map u_index_map (
        .aclk     (aclk),
        .stage_en (stage_en[2:0]),
        .in_data  (s_data),
        .ctl      (ctl),
        .out_data (s2_data)
    );

    // palette memory, stage 3: one op per cycle while the stage advances, in item order
    logic           pal_move;
    logic           pal_we;
    logic           pal_re;
    pcbc_pkg::rgb_t pal_rd;

    assign pal_move = stage_en[ST_MEM] && valid_reg[ST_MEM-1];
    assign pal_we   = pal_move && (s2_data.func == pcbc_pkg::FUNC_WRITE);
    assign pal_re   = pal_move && (s2_data.func == pcbc_pkg::FUNC_MAP);

    pcbc_palette_ram #(
        .DEPTH (MAX_COLORS)
    ) u_palette_ram (
        .aclk    (aclk),
        .wr_en   (pal_we),
        .rd_en   (pal_re),
        .addr    (s2_data.entry[AW-1:0]),
        .wr_data (s2_data.rgb),
        .rd_data (pal_rd)
    );

    logic       s3_black_reg;
    logic [7:0] s3_entry_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[ST_MEM]) begin
            s3_black_reg <= s2_data.black;
            s3_entry_reg <= s2_data.entry;
        end
    end

    // gray ramp divider, stages 4..9, with side data carried alongside
    logic [pcbc_pkg::RAMP_Q_W-1:0] ramp_q;
    pcbc_pkg::side_t               side_reg [pcbc_pkg::DIV_STAGES];

    pcbc_ramp_div u_ramp_div (
        .aclk     (aclk),
        .stage_en (stage_en[ST_DIV0 +: pcbc_pkg::DIV_STAGES]),
        .entry_in (s3_entry_reg),
        .n_colors (n_colors),
        .quot     (ramp_q)
    );

    always_ff @(posedge aclk) begin
        if (stage_en[ST_DIV0]) begin
            side_reg[0] <= '{black: s3_black_reg, entry: s3_entry_reg[6:0], rgb: pal_rd};
        end
        for (int k = 1; k < pcbc_pkg::DIV_STAGES; k++) begin
            if (stage_en[ST_DIV0 + k]) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // output register: black, loaded color or saturated ramp level
    pcbc_pkg::side_t    side_last;
    logic [15:0]        gray;
    pcbc_pkg::pix_out_t m_data_next;
    pcbc_pkg::pix_out_t m_data_reg;

    always_comb begin
        side_last = side_reg[pcbc_pkg::DIV_STAGES-1];
        gray = (ramp_q > {1'b0, pcbc_pkg::GRAY_MAX}) ? pcbc_pkg::GRAY_MAX : ramp_q[15:0];
        m_data_next.palette_entry = side_last.entry;
        if (side_last.black) begin
            m_data_next.red_out   = '0;
            m_data_next.green_out = '0;
            m_data_next.blue_out  = '0;
        end else if (source_reg == pcbc_pkg::SRC_LOADED) begin
            m_data_next.red_out   = side_last.rgb.red;
            m_data_next.green_out = side_last.rgb.green;
            m_data_next.blue_out  = side_last.rgb.blue;
        end else begin
            m_data_next.red_out   = gray;
            m_data_next.green_out = gray;
            m_data_next.blue_out  = gray;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_OUT]) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = valid_reg[ST_OUT];
    assign m_data  = m_data_reg;

    // input stalls only when the result side is back-pressured
    a_stall_from_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without output back-pressure");

    // remapped entry at the memory stage is 0 exactly for index 0, else below n
    a_entry_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[ST_MEM] |-> ((s3_black_reg == (s3_entry_reg == 8'd0)) &&
                               (s3_entry_reg < n_colors)))
        else $error("remapped palette entry out of range");

    // (j+1) <= n bounds the ramp quotient
    a_ramp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[ST_OUT-1] |-> (ramp_q <= pcbc_pkg::RAMP_Q_MAX))
        else $error("gray ramp quotient above bound");

    // gray ramp gives equal channels
    a_gray_equal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (source_reg == pcbc_pkg::SRC_RAMP)) |->
            ((m_data.red_out == m_data.green_out) && (m_data.green_out == m_data.blue_out)))
        else $error("gray ramp channels differ");

endmodule
